// File: sv/tga_psd_pkg.sv
// Shared types and constants for the TGA pixel stream decoder.
// Holds the request structs, register index codes and conversion mode codes.
// Depends on nothing.
package tga_psd_pkg;

	localparam int unsigned CfgWidth = 32;

	localparam logic [7:0] CountMask = 8'h7f;
	localparam logic [7:0] RunFlag   = 8'h80;

	typedef enum logic [1:0] {
		CFG_BYTES_PER_PIXEL = 2'd0,
		CFG_RLE_ENABLE      = 2'd1,
		CFG_SWAP_MODE       = 2'd2,
		CFG_PIXEL_TOTAL     = 2'd3
	} cfg_idx_t;

	typedef enum logic [1:0] {
		SWAP_NONE   = 2'd0,
		SWAP_RB     = 2'd1,
		SWAP_REPACK = 2'd2,
		SWAP_RSVD   = 2'd3
	} swap_mode_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       start_image;
	} in_req_t;

	typedef struct packed {
		logic [31:0] pixel_value;
		logic [7:0]  repeat_count;
		logic        image_done;
		logic        run_overflow;
	} out_req_t;

endpackage

// File: sv/tga_pixel_stream_decoder.sv
// Top level of the TGA pixel stream decoder: input register, byte decode and result register.
// Depends on tga_psd_pkg for the request structs and the register codes.
//
// The input channel takes one pixel-data byte per request with a start_image flag that
// restarts decoding at pixel zero. The output channel delivers one converted pixel with its
// repeat count, an image end flag and a clipped-run flag. Header bytes, partial pixel bytes
// and bytes after the image end produce no output request.
// Both channels use valid and stall; a request moves when valid is high and stall is low.
// Registers are written through cfg_we, cfg_index and cfg_data; the user must write them only
// while the block is idle, which the block does not enforce. A taken byte is held in the input
// register and decoded from there; when it is processed, its result, if any, is loaded into the
// output register. Throughput is one byte per cycle while the receiver does not stall: the decode
// step is a single pass of byte assembly, packet count and 32-bit arithmetic on the pixel total.
// When the receiver stalls with a result waiting, the byte in the input register is held and
// the input stalls while that register is full; full rate resumes when the stall drops.
// Reset clears all decode state and loads the registers with pixel size 3, raw mode,
// red/blue swap and a pixel total of one.
module tga_pixel_stream_decoder (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  tga_psd_pkg::in_req_t                in_data,
	output logic                                out_valid,
	input  logic                                out_stall,
	output tga_psd_pkg::out_req_t               out_data,
	input  logic                                cfg_we,
	input  tga_psd_pkg::cfg_idx_t               cfg_index,
	input  logic [tga_psd_pkg::CfgWidth-1:0]    cfg_data
);
	import tga_psd_pkg::*;

	logic [2:0]  bytes_per_pixel_q;
	logic        rle_enable_q;
	swap_mode_t  swap_mode_q;
	logic [31:0] pixel_total_q;

	logic [31:0] pixels_done_q, pixels_done_d;
	logic [7:0]  packet_left_q, packet_left_d;
	logic        packet_is_run_q, packet_is_run_d;
	logic [1:0]  byte_index_q, byte_index_d;
	logic [23:0] pixel_buffer_q, pixel_buffer_d;
	logic [7:0]  run_length_q, run_length_d;

	logic        valid_s1;
	in_req_t     in_s1;
	logic        out_valid_q;
	out_req_t    out_q;

	logic        proc;
	logic        emit;
	out_req_t    res;

	assign proc      = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall  = valid_s1 && !proc;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bytes_per_pixel_q <= 3'd3;
			rle_enable_q      <= 1'b0;
			swap_mode_q       <= SWAP_RB;
			pixel_total_q     <= 32'd1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_BYTES_PER_PIXEL: bytes_per_pixel_q <= cfg_data[2:0];
				CFG_RLE_ENABLE:      rle_enable_q      <= cfg_data[0];
				CFG_SWAP_MODE:       swap_mode_q       <= swap_mode_t'(cfg_data[1:0]);
				CFG_PIXEL_TOTAL:     pixel_total_q     <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		logic [2:0]  size;
		logic [7:0]  b;
		logic [31:0] px;
		logic [31:0] cv;
		logic [31:0] remaining;
		logic [7:0]  repeat_n;
		logic        ovf;
		logic        more;
		logic        done_flag;

		b    = in_s1.data_byte;
		size = bytes_per_pixel_q;
		if (bytes_per_pixel_q == 3'd0) begin
			size = 3'd1;
		end else if (bytes_per_pixel_q > 3'd4) begin
			size = 3'd4;
		end

		if (in_s1.start_image) begin
			pixels_done_d   = '0;
			packet_left_d   = '0;
			packet_is_run_d = 1'b0;
			byte_index_d    = '0;
			pixel_buffer_d  = '0;
			run_length_d    = '0;
		end else begin
			pixels_done_d   = pixels_done_q;
			packet_left_d   = packet_left_q;
			packet_is_run_d = packet_is_run_q;
			byte_index_d    = byte_index_q;
			pixel_buffer_d  = pixel_buffer_q;
			run_length_d    = run_length_q;
		end

		emit      = 1'b0;
		res       = '0;
		px        = '0;
		cv        = '0;
		remaining = pixel_total_q - pixels_done_d;
		repeat_n  = 8'd1;
		ovf       = 1'b0;
		more      = 1'b0;
		done_flag = 1'b0;

		if (pixels_done_d >= pixel_total_q) begin
			emit = 1'b0;
		end else if (rle_enable_q && packet_left_d == 8'd0) begin
			packet_is_run_d = (b & RunFlag) != 8'd0;
			run_length_d    = (b & CountMask) + 8'd1;
			packet_left_d   = (b & CountMask) + 8'd1;
			byte_index_d    = '0;
			pixel_buffer_d  = '0;
		end else if ({1'b0, byte_index_d} + 3'd1 < size) begin
			unique case (byte_index_d)
				2'd0: pixel_buffer_d[7:0]   = b;
				2'd1: pixel_buffer_d[15:8]  = b;
				2'd2: pixel_buffer_d[23:16] = b;
				2'd3: pixel_buffer_d        = pixel_buffer_d;
			endcase
			byte_index_d = byte_index_d + 2'd1;
		end else begin
			unique case (size)
				3'd1:    px = {24'd0, pixel_buffer_d[7:0] | b};
				3'd2:    px = {16'd0, pixel_buffer_d[15:8] | b, pixel_buffer_d[7:0]};
				3'd3:    px = {8'd0, pixel_buffer_d[23:16] | b, pixel_buffer_d[15:0]};
				default: px = {b, pixel_buffer_d};
			endcase
			byte_index_d   = '0;
			pixel_buffer_d = '0;

			if (!rle_enable_q) begin
				repeat_n = 8'd1;
			end else if (packet_is_run_d) begin
				repeat_n      = run_length_d;
				packet_left_d = '0;
			end else begin
				repeat_n      = 8'd1;
				packet_left_d = packet_left_d - 8'd1;
				more          = packet_left_d != 8'd0;
			end

			if ({24'd0, repeat_n} > remaining) begin
				repeat_n = remaining[7:0];
				ovf      = 1'b1;
			end
			done_flag     = {24'd0, repeat_n} == remaining;
			pixels_done_d = pixels_done_d + {24'd0, repeat_n};
			if (done_flag && more) begin
				ovf = 1'b1;
			end

			cv = px;
			if (swap_mode_q == SWAP_RB && size >= 3'd3) begin
				cv = {px[31:24], px[7:0], px[15:8], px[23:16]};
			end else if (swap_mode_q == SWAP_REPACK && size >= 3'd2) begin
				cv = {px[31:16], px[6:0], px[15], px[14:8], px[7]};
			end

			emit             = 1'b1;
			res.pixel_value  = cv;
			res.repeat_count = repeat_n;
			res.image_done   = done_flag;
			res.run_overflow = ovf;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixels_done_q   <= '0;
			packet_left_q   <= '0;
			packet_is_run_q <= 1'b0;
			byte_index_q    <= '0;
			pixel_buffer_q  <= '0;
			run_length_q    <= '0;
		end else if (proc) begin
			pixels_done_q   <= pixels_done_d;
			packet_left_q   <= packet_left_d;
			packet_is_run_q <= packet_is_run_d;
			byte_index_q    <= byte_index_d;
			pixel_buffer_q  <= pixel_buffer_d;
			run_length_q    <= run_length_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (proc) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			in_s1 <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (proc) begin
			out_valid_q <= emit;
		end else if (out_valid_q && !out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (proc && emit) begin
			out_q <= res;
		end
	end

	// A run can only be clipped on the request that ends the image.
	a_ovf_ends_image: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.run_overflow |-> out_data.image_done)
		else $error("run_overflow without image_done");

	a_repeat_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.repeat_count != 8'd0)
		else $error("zero repeat count");

	// The input register only stalls while it holds a byte.
	a_stall_needs_s1: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1)
		else $error("input stalled with empty input register");

	a_done_reaches_total: assert property (@(posedge clk) disable iff (!arst_n)
		proc && emit && res.image_done && !cfg_we |=> pixels_done_q == pixel_total_q)
		else $error("image_done without reaching the pixel total");

endmodule
